// ===== rtl/core/plos_pkg.sv =====
// Shared types and codes for the polygon line-of-sight block.
// Holds the command and outcome codes and the controller state type; no dependencies.
package plos_pkg;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] OUTCOME_VISIBLE = 2'd0;
   localparam logic [1:0] OUTCOME_BLOCKED = 2'd1;
   localparam logic [1:0] OUTCOME_OUTSIDE = 2'd2;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_FETCH   = 11'b000_0000_0010,
      ST_DIFF    = 11'b000_0000_0100,
      ST_MUL_DEN = 11'b000_0000_1000,
      ST_MUL_NUM = 11'b000_0001_0000,
      ST_MUL_QN  = 11'b000_0010_0000,
      ST_MUL_MID = 11'b000_0100_0000,
      ST_NORM    = 11'b000_1000_0000,
      ST_EVAL    = 11'b001_0000_0000,
      ST_DONE    = 11'b010_0000_0000,
      ST_RESP    = 11'b100_0000_0000
   } plos_state_type;

endpackage

// ===== rtl/core/polygon_line_of_sight.sv =====
// Polygon line-of-sight unit: corner memories, edge walker and result register.
// Depends on plos_pkg for the command and outcome codes and the state type.
//
//   Channel  Ports                               Direction  Moves
//   req      req_valid/req_stall + 8 fields      in         vertex write or query word
//   rsp      rsp_valid/rsp_stall + 2 fields      out        one result word per query
//   csr      csr_wr_en/csr_wr_data               in         ring vertex count
//
// A query walks the ring one edge at a time: each edge has a fetch step and seven steps
// (DIFF, MUL_DEN, MUL_NUM, MUL_QN, MUL_MID, NORM, EVAL) through the two shared
// multipliers; the first edge fetches twice and the closing edge not at all.
// One word is in work at a time; req_stall is high from a query until its result is taken.
// Reset is synchronous and sets the vertex count to three; the corner memories are not cleared.
// The result holds on rsp_* while rsp_stall is high.
module polygon_line_of_sight #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [5:0]  req_vertex_index,
   input  logic [31:0] req_vertex_x,
   input  logic [31:0] req_vertex_y,
   input  logic [31:0] req_observer_x,
   input  logic [31:0] req_observer_y,
   input  logic [31:0] req_target_x,
   input  logic [31:0] req_target_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_visible,
   output logic [1:0]  rsp_outcome,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   localparam int CW     = COORD_WIDTH;
   localparam int MW     = COORD_WIDTH + 2;
   localparam int PW     = 2 * MW;
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

   logic signed [CW-1:0] corner_x_mem [MAX_VERTICES];
   logic signed [CW-1:0] corner_y_mem [MAX_VERTICES];

   plos_pkg::plos_state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ridx_ff, ridx_in, ridx_nx;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_acc, is_query, mem_we, rd_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;

   logic signed [CW-1:0] rd_x_ff, rd_y_ff;
   logic signed [CW-1:0] a_x_ff, a_y_ff, b_x_ff, b_y_ff, v0_x_ff, v0_y_ff;
   logic signed [MW-1:0] ox_ff, oy_ff, dx_ff, dy_ff, mx2_ff, my2_ff;
   logic signed [MW-1:0] ex_ff, ey_ff, wx_ff, wy_ff;
   logic signed [MW-1:0] mxd_ff, myd_ff, rx_ff, ry_ff;
   logic signed [MW-1:0] ma0, mb0, ma1, mb1;
   logic signed [MW-1:0] ax_e, ay_e, bx_e, by_e, ay2, bx2, by2;
   logic signed [PW-1:0] p0_ff, p1_ff;
   logic signed [PW:0]   pdiff, den_ff, num_ff, qn_ff;
   logic                 ycross_ff, onv_ff, left_ff, hit;
   logic                 any_hit_ff, any_nz_ff, any_short_ff, inside_ff, on_vertex_ff;
   logic                 visible_ff;
   logic [1:0]           outcome_ff;

   assign req_stall   = (state_ff != plos_pkg::ST_IDLE);
   assign req_acc     = req_valid && !req_stall;
   assign is_query    = (req_command == plos_pkg::CMD_QUERY);
   assign mem_we      = req_acc && !is_query && (int'(req_vertex_index) < MAX_VERTICES);
   assign wr_addr     = ADDR_W'(req_vertex_index);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = visible_ff;
   assign rsp_outcome = outcome_ff;
   assign ridx_nx     = ridx_ff + CNT_W'(1);

   assign ax_e  = MW'(a_x_ff);
   assign ay_e  = MW'(a_y_ff);
   assign bx_e  = MW'(b_x_ff);
   assign by_e  = MW'(b_y_ff);
   assign ay2   = ay_e <<< 1;
   assign bx2   = bx_e <<< 1;
   assign by2   = by_e <<< 1;
   assign pdiff = (PW+1)'(p0_ff) - (PW+1)'(p1_ff);
   assign hit   = (den_ff != '0) && !num_ff[PW] && !qn_ff[PW] && !(den_ff < qn_ff);

   always_comb begin
      count_in = count_ff;
      if (csr_wr_en) begin
         if (int'(csr_wr_data) > MAX_VERTICES) begin
            count_in = CNT_W'(MAX_VERTICES);
         end else begin
            count_in = CNT_W'(csr_wr_data);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      ridx_in      = ridx_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_en        = 1'b0;
      rd_addr      = ridx_ff[ADDR_W-1:0];
      unique case (state_ff)
         plos_pkg::ST_IDLE: begin
            if (req_acc && is_query) begin
               if (count_ff == '0) begin
                  state_in = plos_pkg::ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  ridx_in  = '0;
                  state_in = plos_pkg::ST_FETCH;
               end
            end
         end
         plos_pkg::ST_FETCH: begin
            if (ridx_ff == '0 && count_ff != CNT_W'(1)) begin
               rd_en   = 1'b1;
               rd_addr = ridx_nx[ADDR_W-1:0];
               ridx_in = ridx_nx;
            end else begin
               last_in  = (count_ff == CNT_W'(1));
               state_in = plos_pkg::ST_DIFF;
            end
         end
         plos_pkg::ST_DIFF:    state_in = plos_pkg::ST_MUL_DEN;
         plos_pkg::ST_MUL_DEN: state_in = plos_pkg::ST_MUL_NUM;
         plos_pkg::ST_MUL_NUM: state_in = plos_pkg::ST_MUL_QN;
         plos_pkg::ST_MUL_QN:  state_in = plos_pkg::ST_MUL_MID;
         plos_pkg::ST_MUL_MID: state_in = plos_pkg::ST_NORM;
         plos_pkg::ST_NORM:    state_in = plos_pkg::ST_EVAL;
         plos_pkg::ST_EVAL: begin
            if (last_ff) begin
               state_in = plos_pkg::ST_DONE;
            end else if (ridx_ff == count_ff - CNT_W'(1)) begin
               last_in  = 1'b1;
               state_in = plos_pkg::ST_DIFF;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ridx_nx[ADDR_W-1:0];
               ridx_in  = ridx_nx;
               state_in = plos_pkg::ST_FETCH;
            end
         end
         plos_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = plos_pkg::ST_RESP;
         end
         plos_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = plos_pkg::ST_IDLE;
            end
         end
         default: state_in = plos_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         plos_pkg::ST_MUL_DEN: begin
            ma0 = ex_ff; mb0 = dy_ff; ma1 = ey_ff; mb1 = dx_ff;
         end
         plos_pkg::ST_MUL_NUM: begin
            ma0 = ex_ff; mb0 = wy_ff; ma1 = ey_ff; mb1 = wx_ff;
         end
         plos_pkg::ST_MUL_QN: begin
            ma0 = dx_ff; mb0 = wy_ff; ma1 = dy_ff; mb1 = wx_ff;
         end
         default: begin
            ma0 = mxd_ff; mb0 = ry_ff; ma1 = rx_ff; mb1 = myd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plos_pkg::ST_IDLE;
         count_ff     <= CNT_W'(3);
         ridx_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ridx_ff      <= ridx_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         corner_x_mem[wr_addr] <= req_vertex_x[CW-1:0];
         corner_y_mem[wr_addr] <= req_vertex_y[CW-1:0];
      end
      if (rd_en) begin
         rd_x_ff <= corner_x_mem[rd_addr];
         rd_y_ff <= corner_y_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      p0_ff <= ma0 * mb0;
      p1_ff <= ma1 * mb1;
      unique case (state_ff)
         plos_pkg::ST_IDLE: begin
            if (req_acc && is_query) begin
               ox_ff  <= MW'($signed(req_observer_x[CW-1:0]));
               oy_ff  <= MW'($signed(req_observer_y[CW-1:0]));
               dx_ff  <= MW'($signed(req_target_x[CW-1:0]))
                         - MW'($signed(req_observer_x[CW-1:0]));
               dy_ff  <= MW'($signed(req_target_y[CW-1:0]))
                         - MW'($signed(req_observer_y[CW-1:0]));
               mx2_ff <= MW'($signed(req_target_x[CW-1:0]))
                         + MW'($signed(req_observer_x[CW-1:0]));
               my2_ff <= MW'($signed(req_target_y[CW-1:0]))
                         + MW'($signed(req_observer_y[CW-1:0]));
               any_hit_ff   <= 1'b0;
               any_nz_ff    <= 1'b0;
               any_short_ff <= 1'b0;
               inside_ff    <= 1'b0;
               on_vertex_ff <= 1'b0;
            end
         end
         plos_pkg::ST_FETCH: begin
            if (ridx_ff == '0) begin
               v0_x_ff <= rd_x_ff;
               v0_y_ff <= rd_y_ff;
               a_x_ff  <= rd_x_ff;
               a_y_ff  <= rd_y_ff;
            end else begin
               a_x_ff <= b_x_ff;
               a_y_ff <= b_y_ff;
            end
            b_x_ff <= rd_x_ff;
            b_y_ff <= rd_y_ff;
         end
         plos_pkg::ST_DIFF: begin
            ex_ff     <= bx_e - ax_e;
            ey_ff     <= by_e - ay_e;
            wx_ff     <= ax_e - ox_ff;
            wy_ff     <= ay_e - oy_ff;
            mxd_ff    <= mx2_ff - bx2;
            myd_ff    <= my2_ff - by2;
            rx_ff     <= ax_e - bx_e;
            ry_ff     <= ay_e - by_e;
            ycross_ff <= (by2 <= my2_ff && my2_ff < ay2) || (ay2 <= my2_ff && my2_ff < by2);
            onv_ff    <= (bx2 == mx2_ff) && (by2 == my2_ff);
         end
         plos_pkg::ST_MUL_NUM: den_ff <= pdiff;
         plos_pkg::ST_MUL_QN:  num_ff <= pdiff;
         plos_pkg::ST_MUL_MID: qn_ff  <= pdiff;
         plos_pkg::ST_NORM: begin
            left_ff <= (ry_ff > 0) ? (p0_ff < p1_ff) : (p1_ff < p0_ff);
            if (den_ff[PW]) begin
               den_ff <= -den_ff;
               num_ff <= -num_ff;
               qn_ff  <= -qn_ff;
            end
         end
         plos_pkg::ST_EVAL: begin
            if (hit) begin
               any_hit_ff <= 1'b1;
               if (num_ff != '0) begin
                  any_nz_ff <= 1'b1;
                  if (num_ff < den_ff) begin
                     any_short_ff <= 1'b1;
                  end
               end
            end
            if (ycross_ff && left_ff) begin
               inside_ff <= !inside_ff;
            end
            if (onv_ff) begin
               on_vertex_ff <= 1'b1;
            end
            if (!last_ff && ridx_ff == count_ff - CNT_W'(1)) begin
               a_x_ff <= b_x_ff;
               a_y_ff <= b_y_ff;
               b_x_ff <= v0_x_ff;
               b_y_ff <= v0_y_ff;
            end
         end
         plos_pkg::ST_DONE: begin
            if (any_short_ff || (any_hit_ff && !any_nz_ff)) begin
               visible_ff <= 1'b0;
               outcome_ff <= plos_pkg::OUTCOME_BLOCKED;
            end else if (inside_ff || on_vertex_ff) begin
               visible_ff <= 1'b1;
               outcome_ff <= plos_pkg::OUTCOME_VISIBLE;
            end else begin
               visible_ff <= 1'b0;
               outcome_ff <= plos_pkg::OUTCOME_OUTSIDE;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
